[hw/rtl/clre_pkg.sv]
// Package for the connection list range expander.
// Holds list limits, field widths and the queue word type; depends on nothing.
package clre_pkg;

  localparam int MAX_LIST     = 32;
  localparam int CNT_W        = $clog2(MAX_LIST + 1);
  localparam int STEP_RESULTS = 32;
  localparam int PROD_W       = $clog2(STEP_RESULTS + 1);
  localparam int ENTRIES      = 4;

  localparam logic [7:0] MARK_BIT = 8'h80;
  localparam logic [7:0] END_MASK = 8'h7F;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        start;
  } clre_item_t;

endpackage

[hw/rtl/clre_front.sv]
// Front end of the connection list range expander: accepts response words,
// clamps the entry count and holds them in a two-word queue. Uses clre_pkg.
module clre_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,
  input  logic                in_tuser,
  output logic                q_valid,
  output clre_pkg::clre_item_t q_item,
  input  logic                q_pop
);
  import clre_pkg::*;

  clre_item_t  mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        push;
  logic        pop;
  clre_item_t  item_in;
  logic [2:0]  cnt_raw;

  assign cnt_raw       = in_tdata[34:32];
  assign item_in.word  = in_tdata[31:0];
  assign item_in.cnt   = (cnt_raw > 3'(ENTRIES)) ? 3'(ENTRIES) : cnt_raw;
  assign item_in.start = in_tuser;

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("full queue with unequal pointers");

endmodule

[hw/rtl/clre_back.sv]
// Back end of the connection list range expander: walks one word's entries,
// expands ranges one node a cycle unless stalled; registers results. Uses clre_pkg.
module clre_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  clre_pkg::clre_item_t q_item,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast
);
  import clre_pkg::*;

  logic              busy_r, busy_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              in_range_r, in_range_nxt;
  logic [7:0]        node_r, node_nxt;
  logic [6:0]        end_r, end_nxt;
  logic [CNT_W-1:0]  emitted_r, emitted_nxt;
  logic [7:0]        prev_r, prev_nxt;
  logic [PROD_W-1:0] produced_r, produced_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [7:0]        pend_node_r, pend_node_nxt;
  logic [4:0]        pend_pos_r, pend_pos_nxt;
  logic              out_v_r, out_v_nxt;
  logic [7:0]        out_node_r, out_node_nxt;
  logic [4:0]        out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;

  logic       room;
  logic       out_free;
  logic [7:0] entry;
  logic       gen;
  logic [7:0] gen_node;
  logic       finish;
  logic       push;
  logic       stall;

  assign room     = (emitted_r < CNT_W'(MAX_LIST)) && (produced_r < PROD_W'(STEP_RESULTS));
  assign out_free = !out_v_r || out_tready;
  assign entry    = word_r[{idx_r[1:0], 3'b000} +: 8];

  always_comb begin
    gen      = 1'b0;
    gen_node = entry;
    finish   = 1'b0;
    if (busy_r) begin
      if (in_range_r) begin
        gen      = ({1'b0, end_r} >= node_r) && room;
        gen_node = node_r;
      end else if (idx_r < cnt_r) begin
        gen = !(((entry & MARK_BIT) != 8'h00) && (emitted_r != '0)) && room;
      end else begin
        finish = 1'b1;
      end
    end
  end

  assign push  = (gen || finish) && pend_v_r;
  assign stall = push && !out_free;
  assign q_pop = !busy_r && q_valid;

  always_comb begin
    busy_nxt      = busy_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    in_range_nxt  = in_range_r;
    node_nxt      = node_r;
    end_nxt       = end_r;
    emitted_nxt   = emitted_r;
    prev_nxt      = prev_r;
    produced_nxt  = produced_r;
    pend_v_nxt    = pend_v_r;
    pend_node_nxt = pend_node_r;
    pend_pos_nxt  = pend_pos_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_node_nxt  = out_node_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;

    if (!busy_r) begin
      if (q_valid) begin
        busy_nxt     = 1'b1;
        word_nxt     = q_item.word;
        cnt_nxt      = q_item.cnt;
        idx_nxt      = 3'd0;
        in_range_nxt = 1'b0;
        produced_nxt = '0;
        if (q_item.start) begin
          emitted_nxt = '0;
          prev_nxt    = 8'h00;
        end
      end
    end else if (!stall) begin
      if (push) begin
        out_v_nxt    = 1'b1;
        out_node_nxt = pend_node_r;
        out_pos_nxt  = pend_pos_r;
        out_last_nxt = finish;
        pend_v_nxt   = 1'b0;
      end
      if (gen) begin
        pend_v_nxt    = 1'b1;
        pend_node_nxt = gen_node;
        pend_pos_nxt  = emitted_r[4:0];
        emitted_nxt   = emitted_r + CNT_W'(1);
        produced_nxt  = produced_r + PROD_W'(1);
        prev_nxt      = gen_node;
      end
      if (finish) begin
        busy_nxt = 1'b0;
      end else if (in_range_r) begin
        if (gen) begin
          node_nxt = node_r + 8'd1;
        end else begin
          in_range_nxt = 1'b0;
          idx_nxt      = idx_r + 3'd1;
        end
      end else if (((entry & MARK_BIT) != 8'h00) && (emitted_r != '0)) begin
        if ({1'b0, entry[6:0]} > prev_r) begin
          in_range_nxt = 1'b1;
          node_nxt     = prev_r + 8'd1;
          end_nxt      = entry[6:0];
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      in_range_r <= 1'b0;
      idx_r      <= 3'd0;
      cnt_r      <= 3'd0;
      emitted_r  <= '0;
      prev_r     <= 8'h00;
      produced_r <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      in_range_r <= in_range_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
      emitted_r  <= emitted_nxt;
      prev_r     <= prev_nxt;
      produced_r <= produced_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    node_r      <= node_nxt;
    end_r       <= end_nxt;
    pend_node_r <= pend_node_nxt;
    pend_pos_r  <= pend_pos_nxt;
    out_node_r  <= out_node_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, out_pos_r, out_node_r};
  assign out_tlast  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) emitted_r <= CNT_W'(MAX_LIST))
    else $error("emitted count beyond list limit");
  assert property (@(posedge clk) disable iff (!rst_n) in_range_r |-> busy_r)
    else $error("range active while idle");
  assert property (@(posedge clk) disable iff (!rst_n) !busy_r |-> !pend_v_r)
    else $error("result pending while idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_range_r |-> (node_r <= {1'b0, end_r} + 8'd1))
    else $error("range walked past its end");

endmodule

[hw/rtl/connection_list_range_expander.sv]
// Connection list range expander: decodes short-form connection list words
// into node numbers. Depends on clre_pkg, clre_front and clre_back.
// The first node of a word passes the queue, the word register, the pending
// result register and the output register; opening a range, skipped entries and
// a busy back end delay it. A word is loaded, its entries are walked in order, range
// nodes are made in turn, each range closes, then the word; the queue buffers new words.
// Reset: synchronous active-low rst_n empties the queue and clears list state.
module connection_list_range_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] response_word, [34:32] valid_entries
  input  logic        in_tuser,   // [0] starts_list
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] node_id, [12:8] position
  output logic        out_tlast
);
  import clre_pkg::*;

  logic       q_valid;
  clre_item_t q_item;
  logic       q_pop;

  clre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  clre_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
